[hw/rtl/pkcs1_chk_pkg.sv]
package pkcs1_chk_pkg;

  // Widths fixed by the field definitions
  localparam int unsigned ByteW   = 8;
  localparam int unsigned PosW    = 10;
  localparam int unsigned BtW     = 2;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 10;
  localparam int unsigned KCmpW   = PosW + 1;

  localparam int unsigned MaxModulusBytes = 512;

  localparam logic [PosW-1:0] MinModulusBytes = 10'd11;
  localparam logic [PosW-1:0] MinSepPos       = 10'd10;

  localparam logic [PosW-1:0] RstModulusBytes = 10'd256;
  localparam logic [BtW-1:0]  RstBlockType    = 2'd2;
  localparam logic [PosW-1:0] RstMaxMsgBytes  = 10'd512;

  localparam logic [ByteW-1:0] ByteZero = 8'h00;
  localparam logic [ByteW-1:0] ByteFf   = 8'hFF;
  localparam logic [BtW-1:0]   BtSign   = 2'd1;

  typedef enum logic [CfgIdxW-1:0] {
    CfgModulusBytes = 2'd0,
    CfgBlockType    = 2'd1,
    CfgMaxMsgBytes  = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PhHeader  = 2'd0,
    PhPad     = 2'd1,
    PhPayload = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    ErrNone    = 2'd0,
    ErrHeader  = 2'd1,
    ErrPadding = 2'd2,
    ErrLength  = 2'd3
  } err_e;

  // Request handed from classifier to output stage
  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             pld_valid;
    logic             done;
    err_e             status;
    logic [PosW-1:0]  sep_pos;
  } req_t;

  // First error wins
  function automatic err_e flag_err(err_e cur, err_e code);
    return (cur == ErrNone) ? code : cur;
  endfunction

endpackage

[hw/rtl/pkcs1_chk_front.sv]
module pkcs1_chk_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [pkcs1_chk_pkg::PosW-1:0]  k_i,
  input  logic [pkcs1_chk_pkg::BtW-1:0]   block_type_i,
  input  logic [pkcs1_chk_pkg::PosW-1:0]  max_msg_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [pkcs1_chk_pkg::ByteW-1:0] em_byte_i,
  input  logic                            q_full_i,
  output logic                            push_o,
  output pkcs1_chk_pkg::req_t             push_req_o
);
  import pkcs1_chk_pkg::*;

  logic [PosW-1:0] pos_q, pos_d, sep_q, sep_d, rem;
  phase_e          phase_q, phase_d;
  err_e            err_q, err_d;
  logic [KCmpW-1:0] pos_inc;
  logic            last, emit, accept;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign pos_inc    = {1'b0, pos_q} + KCmpW'(1);
  assign last       = (pos_inc >= {1'b0, k_i});
  assign rem        = (k_i > pos_q) ? (k_i - pos_q - PosW'(1)) : '0;

  always_comb begin
    phase_d = phase_q;
    err_d   = err_q;
    sep_d   = sep_q;
    emit    = 1'b0;
    unique case (phase_q)
      PhHeader: begin
        if (pos_q == '0) begin
          if (em_byte_i != ByteZero) err_d = flag_err(err_d, ErrHeader);
        end else begin
          if (em_byte_i != {{(ByteW-BtW){1'b0}}, block_type_i}) begin
            err_d = flag_err(err_d, ErrHeader);
          end
          phase_d = PhPad;
        end
      end
      PhPad: begin
        if (em_byte_i == ByteZero) begin
          sep_d = pos_q;
          if (pos_q < MinSepPos)    err_d = flag_err(err_d, ErrPadding);
          else if (max_msg_i < rem) err_d = flag_err(err_d, ErrLength);
          phase_d = PhPayload;
        end else if (block_type_i == BtSign && em_byte_i != ByteFf) begin
          err_d = flag_err(err_d, ErrPadding);
        end
      end
      PhPayload: emit = (err_q == ErrNone);
      default:   phase_d = PhHeader;
    endcase
    // no separator seen by the final byte
    if (last && phase_d != PhPayload) err_d = flag_err(err_d, ErrPadding);

    pos_d = last ? '0 : pos_q + PosW'(1);
  end

  assign push_o               = accept && (emit || last);
  assign push_req_o.data      = emit ? em_byte_i : ByteZero;
  assign push_req_o.pld_valid = emit;
  assign push_req_o.done      = last;
  assign push_req_o.status    = last ? err_d : ErrNone;
  assign push_req_o.sep_pos   = sep_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      phase_q <= PhHeader;
      sep_q   <= '0;
      err_q   <= ErrNone;
    end else if (accept) begin
      pos_q <= pos_d;
      if (last) begin
        phase_q <= PhHeader;
        sep_q   <= '0;
        err_q   <= ErrNone;
      end else begin
        phase_q <= phase_d;
        sep_q   <= sep_d;
        err_q   <= err_d;
      end
    end
  end

endmodule

[hw/rtl/pkcs1_chk_queue.sv]
module pkcs1_chk_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  pkcs1_chk_pkg::req_t push_req_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                empty_o,
  output pkcs1_chk_pkg::req_t head_o
);
  import pkcs1_chk_pkg::*;

  localparam int unsigned Depth = 2;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  req_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) cnt_d = cnt_q + CntW'(1);
    if (pop_i && !push_i) cnt_d = cnt_q - CntW'(1);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_req_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + PtrW'(1);
      if (pop_i)  rd_q <= rd_q + PtrW'(1);
      cnt_q <= cnt_d;
    end
  end

endmodule

[hw/rtl/pkcs1_chk_back.sv]
module pkcs1_chk_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [pkcs1_chk_pkg::PosW-1:0]  k_i,
  input  logic                            q_empty_i,
  input  pkcs1_chk_pkg::req_t             head_i,
  output logic                            pop_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [pkcs1_chk_pkg::ByteW-1:0] payload_byte_o,
  output logic                            payload_valid_o,
  output logic                            done_res_o,
  output logic [1:0]                      status_o,
  output logic [pkcs1_chk_pkg::PosW-1:0]  message_length_o
);
  import pkcs1_chk_pkg::*;

  logic             valid_q;
  logic [ByteW-1:0] byte_q;
  logic             pv_q, done_q;
  err_e             status_q;
  logic [PosW-1:0]  len_q, len_d;
  logic [KCmpW-1:0] sep_inc;

  assign pop_o   = !q_empty_i && (!valid_q || out_ready_i);
  assign sep_inc = {1'b0, head_i.sep_pos} + KCmpW'(1);

  always_comb begin
    len_d = '0;
    if (head_i.done && head_i.status == ErrNone && {1'b0, k_i} > sep_inc) begin
      len_d = k_i - head_i.sep_pos - PosW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      byte_q   <= head_i.data;
      pv_q     <= head_i.pld_valid;
      done_q   <= head_i.done;
      status_q <= head_i.status;
      len_q    <= len_d;
    end
  end

  assign out_valid_o      = valid_q;
  assign payload_byte_o   = byte_q;
  assign payload_valid_o  = pv_q;
  assign done_res_o       = done_q;
  assign status_o         = status_q;
  assign message_length_o = len_q;

endmodule

[hw/rtl/pkcs1_v15_padding_checker.sv]
// Path: an accepted byte is written into the request queue, then into the output
// register, where its result waits until out_ready_i takes it.
// Throughput: one byte per cycle while the queue is not full; the output register
// and a two-entry queue let the classifier keep taking bytes while a result waits
// to be taken. Bytes that yield no result (header, padding) never enter the queue.
// Reset (rst_ni low, asynchronous): message state rearmed, queue and output
// emptied, registers back to k = 256, block type 2, capacity 512.
module pkcs1_v15_padding_checker #(
  parameter int unsigned MAX_MODULUS_BYTES = pkcs1_chk_pkg::MaxModulusBytes
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write port
  input  logic                              cfg_we_i,
  input  logic [pkcs1_chk_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [pkcs1_chk_pkg::CfgW-1:0]    cfg_wdata_i,
  // encoded message bytes in
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [pkcs1_chk_pkg::ByteW-1:0]   em_byte_i,
  // results out
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [pkcs1_chk_pkg::ByteW-1:0]   payload_byte_o,
  output logic                              payload_valid_o,
  output logic                              done_res_o,
  output logic [1:0]                        status_o,
  output logic [pkcs1_chk_pkg::PosW-1:0]    message_length_o
);
  import pkcs1_chk_pkg::*;

  // Configuration registers
  logic [PosW-1:0] mod_bytes_q, max_msg_q;
  logic [BtW-1:0]  block_type_q;

  // Effective message length k, clamped to [11, MAX_MODULUS_BYTES]
  logic [PosW-1:0] k_eff;

  // front -> queue -> back
  logic q_full, q_empty, push, pop;
  req_t push_req, head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_bytes_q  <= RstModulusBytes;
      block_type_q <= RstBlockType;
      max_msg_q    <= RstMaxMsgBytes;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgModulusBytes: mod_bytes_q  <= cfg_wdata_i[PosW-1:0];
        CfgBlockType:    block_type_q <= cfg_wdata_i[BtW-1:0];
        CfgMaxMsgBytes:  max_msg_q    <= cfg_wdata_i[PosW-1:0];
        default:         ; // unused index, write dropped
      endcase
    end
  end

  always_comb begin
    if (mod_bytes_q < MinModulusBytes) begin
      k_eff = MinModulusBytes;
    end else if ({1'b0, mod_bytes_q} > KCmpW'(MAX_MODULUS_BYTES)) begin
      // only reached when the limit is below the register range
      k_eff = PosW'(MAX_MODULUS_BYTES);
    end else begin
      k_eff = mod_bytes_q;
    end
  end

  // Classifier: tracks header / padding / payload phase, flags first error
  pkcs1_chk_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .k_i          (k_eff),
    .block_type_i (block_type_q),
    .max_msg_i    (max_msg_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .em_byte_i    (em_byte_i),
    .q_full_i     (q_full),
    .push_o       (push),
    .push_req_o   (push_req)
  );

  // Short request queue decoupling the two halves
  pkcs1_chk_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_req_i (push_req),
    .full_o     (q_full),
    .pop_i      (pop),
    .empty_o    (q_empty),
    .head_o     (head)
  );

  // Output stage: works out payload length, holds the result register
  pkcs1_chk_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .k_i              (k_eff),
    .q_empty_i        (q_empty),
    .head_i           (head),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .payload_byte_o   (payload_byte_o),
    .payload_valid_o  (payload_valid_o),
    .done_res_o       (done_res_o),
    .status_o         (status_o),
    .message_length_o (message_length_o)
  );

endmodule

[hw/rtl/pkcs1_chk_checker.sv]
module pkcs1_chk_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic [pkcs1_chk_pkg::ByteW-1:0] payload_byte_o,
  input logic                            payload_valid_o,
  input logic                            done_res_o,
  input logic [1:0]                      status_o,
  input logic [pkcs1_chk_pkg::PosW-1:0]  message_length_o
);
  import pkcs1_chk_pkg::*;

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(done_res_o)
      && $stable(payload_byte_o))
    else $error("result dropped while stalled");

  a_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> payload_valid_o || done_res_o)
    else $error("result carries neither payload nor done");

  a_status_at_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !done_res_o |-> status_o == ErrNone && message_length_o == '0)
    else $error("status or length outside the final result");

  a_len_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && message_length_o != '0 |-> status_o == ErrNone)
    else $error("length reported on failed message");

  a_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !payload_valid_o |-> payload_byte_o == ByteZero)
    else $error("payload byte set without payload_valid");

endmodule

bind pkcs1_v15_padding_checker pkcs1_chk_checker u_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .payload_byte_o   (payload_byte_o),
  .payload_valid_o  (payload_valid_o),
  .done_res_o       (done_res_o),
  .status_o         (status_o),
  .message_length_o (message_length_o)
);
